// ----- sv/btbg_pkg.sv -----
`timescale 1ns / 1ps

package btbg_pkg;

    localparam int BTB_ENTRIES   = 16;
    localparam int INDEX_LOW_BIT = 4;
    localparam int IDX_W         = $clog2(BTB_ENTRIES);
    localparam int PC_W          = 32;
    localparam logic [PC_W-1:0] PC_STEP = PC_W'(4);

    typedef enum logic [1:0] {
        OP_PREDICT = 2'd0,
        OP_INSTALL = 2'd1,
        OP_OUTCOME = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        CS_STRONG_NT = 2'd0,
        CS_WEAK_NT   = 2'd1,
        CS_WEAK_T    = 2'd2,
        CS_STRONG_T  = 2'd3
    } ctr_t;

    typedef struct packed {
        logic [1:0]      opcode;
        logic [PC_W-1:0] pc;
        logic [PC_W-1:0] target;
        logic            was_correct;
    } req_t;

    typedef struct packed {
        logic [PC_W-1:0] next_pc;
        logic            hit;
        logic            taken;
        logic [1:0]      counter_state;
    } rsp_t;

    // A correct prediction saturates toward the current direction; a wrong one
    // weakens a strong state and flips a weak state into the weak opposite.
    function automatic ctr_t ctr_update(ctr_t s, logic correct);
        ctr_t n;
        n = s;
        unique case (s)
            CS_STRONG_NT: n = correct ? CS_STRONG_NT : CS_WEAK_NT;
            CS_WEAK_NT:   n = correct ? CS_STRONG_NT : CS_WEAK_T;
            CS_WEAK_T:    n = correct ? CS_STRONG_T  : CS_WEAK_NT;
            CS_STRONG_T:  n = correct ? CS_STRONG_T  : CS_WEAK_T;
            default:      n = s;
        endcase
        return n;
    endfunction

endpackage

// ----- sv/btbg_req_if.sv -----
`timescale 1ns / 1ps

interface btbg_req_if;

    logic                        valid;
    logic                        ready;
    logic [1:0]                  opcode;
    logic [btbg_pkg::PC_W-1:0]   pc;
    logic [btbg_pkg::PC_W-1:0]   target;
    logic                        was_correct;

    modport source (
        output valid,
        output opcode,
        output pc,
        output target,
        output was_correct,
        input  ready
    );

    modport sink (
        input  valid,
        input  opcode,
        input  pc,
        input  target,
        input  was_correct,
        output ready
    );

endinterface

// ----- sv/btbg_rsp_if.sv -----
`timescale 1ns / 1ps

interface btbg_rsp_if;

    logic                        valid;
    logic                        ready;
    logic [btbg_pkg::PC_W-1:0]   next_pc;
    logic                        hit;
    logic                        taken;
    logic [1:0]                  counter_state;

    modport source (
        output valid,
        output next_pc,
        output hit,
        output taken,
        output counter_state,
        input  ready
    );

    modport sink (
        input  valid,
        input  next_pc,
        input  hit,
        input  taken,
        input  counter_state,
        output ready
    );

endinterface

// ----- sv/btb_with_global_two_bit_predictor.sv -----
`timescale 1ns / 1ps

// Direct-mapped branch target buffer with one shared two-bit direction counter.
// A request enters on the req channel and carries an opcode: predict looks up
// the pc, install writes the tag and target of the indexed entry, and outcome
// moves the shared counter. Every request yields exactly one response on the
// rsp channel with the next pc, the hit flag, the taken flag and the counter.
// Both channels use valid and ready; a request is taken when both are high.
// A request is registered in the input stage, looked up and applied when it
// leaves that stage, and its response is registered in the output register.
// One request per cycle while rsp.ready is high; the lookup is a single indexed
// read of the entry registers followed by a compare and the counter update.
// When the receiver holds rsp.ready low, the response waits in its register,
// one more request waits in the input register, and then req.ready drops.
// Reset clears all entry valid bits and the response and input stages, and
// sets the counter to weakly taken; the block takes requests right after reset.
module btb_with_global_two_bit_predictor (
    input  logic             clk,
    input  logic             rst_n,
    btbg_req_if.sink         req,
    btbg_rsp_if.source       rsp
);

    logic                                s1_valid_reg;
    btbg_pkg::req_t                      s1_reg;
    logic                                out_valid_reg;
    btbg_pkg::rsp_t                      out_reg;
    btbg_pkg::rsp_t                      out_next;
    btbg_pkg::ctr_t                      state_reg;
    btbg_pkg::ctr_t                      state_next;
    logic [btbg_pkg::BTB_ENTRIES-1:0]    valid_reg;
    logic [btbg_pkg::PC_W-1:0]           tag_reg    [btbg_pkg::BTB_ENTRIES];
    logic [btbg_pkg::PC_W-1:0]           target_reg [btbg_pkg::BTB_ENTRIES];

    logic                                advance;
    logic [btbg_pkg::IDX_W-1:0]          idx;
    logic                                hit;
    logic [btbg_pkg::PC_W-1:0]           seq_pc;
    btbg_pkg::opcode_t                   op;

    assign advance   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;
    assign op        = btbg_pkg::opcode_t'(s1_reg.opcode);
    assign idx       = s1_reg.pc[btbg_pkg::INDEX_LOW_BIT +: btbg_pkg::IDX_W];
    assign hit       = valid_reg[idx] && (tag_reg[idx] == s1_reg.pc);
    assign seq_pc    = s1_reg.pc + btbg_pkg::PC_STEP;

    always_comb
    begin
        state_next       = state_reg;
        out_next.next_pc = seq_pc;
        unique case (op)
            btbg_pkg::OP_PREDICT:
            begin
                if (hit && state_reg[1])
                begin
                    out_next.next_pc = target_reg[idx];
                end
            end
            btbg_pkg::OP_OUTCOME:
            begin
                state_next = btbg_pkg::ctr_update(state_reg, s1_reg.was_correct);
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
        out_next.hit           = hit;
        out_next.taken         = state_next[1];
        out_next.counter_state = state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= btbg_pkg::CS_WEAK_T;
            valid_reg     <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
                if (op == btbg_pkg::OP_INSTALL)
                begin
                    valid_reg[idx] <= 1'b1;
                end
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_reg.opcode      <= req.opcode;
            s1_reg.pc          <= req.pc;
            s1_reg.target      <= req.target;
            s1_reg.was_correct <= req.was_correct;
        end
        if (advance)
        begin
            out_reg <= out_next;
            if (op == btbg_pkg::OP_INSTALL)
            begin
                tag_reg[idx]    <= s1_reg.pc;
                target_reg[idx] <= s1_reg.target;
            end
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.next_pc       = out_reg.next_pc;
    assign rsp.hit           = out_reg.hit;
    assign rsp.taken         = out_reg.taken;
    assign rsp.counter_state = out_reg.counter_state;

    // A request that leaves the input stage always shows up as a response.
    a_advance_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp.valid)
        else $error("request left the input stage without a response");

    // The input stage only blocks new requests while it holds one.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> req.ready)
        else $error("input stage empty but request not accepted");

    // The shared counter moves only on an outcome request.
    a_state_only_on_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && (op == btbg_pkg::OP_OUTCOME)) |=> $stable(state_reg))
        else $error("counter changed without an outcome request");

    // An install leaves its entry valid in the following cycle.
    a_install_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (op == btbg_pkg::OP_INSTALL)) |=> valid_reg[$past(idx)])
        else $error("installed entry not marked valid");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;

    import btbg_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         POOL_SIZE = 24;
    localparam int         RANDOM_REQUESTS = 1950;

    typedef struct {
        req_t r;
        bit   drain;
    } pending_t;

    logic clk;
    logic rst_n;

    btbg_req_if req_ch ();
    btbg_rsp_if rsp_ch ();

    btb_with_global_two_bit_predictor dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    pending_t        pending[$];
    rsp_t            expected_rsp[$];
    int              mismatches = 0;

    ctr_t            dir_state;
    logic [PC_W-1:0] btb_tag[BTB_ENTRIES];
    logic [PC_W-1:0] btb_target[BTB_ENTRIES];
    logic            btb_valid[BTB_ENTRIES];

    logic [PC_W-1:0] addr_pool[POOL_SIZE];

    int              gap_left = 0;
    int              burst_left = 0;
    bit              launched;
    int              ready_window = 0;
    int              ready_style = 0;
    rsp_t            want_rsp;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Mirrors one request into the shadow buffer and returns its response.
    function automatic rsp_t apply_request(req_t r);
        rsp_t                 o;
        logic [IDX_W-1:0]     slot;
        logic                 hit_now;
        slot    = r.pc[INDEX_LOW_BIT +: IDX_W];
        hit_now = btb_valid[slot] && (btb_tag[slot] == r.pc);
        o.next_pc = r.pc + PC_STEP;
        case (r.opcode)
            OP_PREDICT:
                if (hit_now && (dir_state == CS_WEAK_T || dir_state == CS_STRONG_T))
                    o.next_pc = btb_target[slot];
            OP_INSTALL:
            begin
                btb_tag[slot]    = r.pc;
                btb_target[slot] = r.target;
                btb_valid[slot]  = 1'b1;
            end
            OP_OUTCOME:
            begin
                case (dir_state)
                    CS_STRONG_NT: dir_state = r.was_correct ? CS_STRONG_NT : CS_WEAK_NT;
                    CS_WEAK_NT:   dir_state = r.was_correct ? CS_STRONG_NT : CS_WEAK_T;
                    CS_WEAK_T:    dir_state = r.was_correct ? CS_STRONG_T  : CS_WEAK_NT;
                    default:      dir_state = r.was_correct ? CS_STRONG_T  : CS_WEAK_T;
                endcase
            end
            default:
            begin
            end
        endcase
        o.hit           = hit_now;
        o.taken         = (dir_state == CS_WEAK_T || dir_state == CS_STRONG_T);
        o.counter_state = dir_state;
        return o;
    endfunction

    task automatic add_req(input logic [1:0] op, input logic [PC_W-1:0] pc,
                           input logic [PC_W-1:0] tgt, input logic wc,
                           input bit drain = 1'b0);
        pending_t p;
        p.r.opcode      = op;
        p.r.pc          = pc;
        p.r.target      = tgt;
        p.r.was_correct = wc;
        p.drain         = drain;
        pending.push_back(p);
    endtask

    // Request driver: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid       <= 1'b0;
            req_ch.opcode      <= OP_PREDICT;
            req_ch.pc          <= '0;
            req_ch.target      <= '0;
            req_ch.was_correct <= 1'b0;
        end
        else
        begin
            launched = 1'b0;
            if (req_ch.valid && req_ch.ready)
            begin
                expected_rsp.push_back(apply_request('{req_ch.opcode, req_ch.pc,
                                                       req_ch.target, req_ch.was_correct}));
                launched = 1'b1;
            end
            if (!req_ch.valid || launched)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending.size() > 0 &&
                         !(pending[0].drain && (launched || expected_rsp.size() != 0)))
                begin
                    req_ch.opcode      <= pending[0].r.opcode;
                    req_ch.pc          <= pending[0].r.pc;
                    req_ch.target      <= pending[0].r.target;
                    req_ch.was_correct <= pending[0].r.was_correct;
                    req_ch.valid       <= 1'b1;
                    void'(pending.pop_front());
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // Response back-pressure: each window picks its own stall style.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (ready_window == 0)
            begin
                ready_window = $urandom_range(20, 200);
                ready_style  = $urandom_range(0, 3);
            end
            else
                ready_window--;
            case (ready_style)
                0:       rsp_ch.ready <= 1'b1;
                1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                2:       rsp_ch.ready <= ($urandom_range(0, 7) != 0);
                default: rsp_ch.ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                $display("%0t: unexpected response next_pc %h hit %b taken %b state %0d",
                         $time, rsp_ch.next_pc, rsp_ch.hit, rsp_ch.taken,
                         rsp_ch.counter_state);
                mismatches++;
            end
            else
            begin
                want_rsp = expected_rsp.pop_front();
                if (rsp_ch.next_pc !== want_rsp.next_pc)
                begin
                    $display("%0t: next_pc expected %h actual %h",
                             $time, want_rsp.next_pc, rsp_ch.next_pc);
                    mismatches++;
                end
                if (rsp_ch.hit !== want_rsp.hit)
                begin
                    $display("%0t: hit expected %b actual %b",
                             $time, want_rsp.hit, rsp_ch.hit);
                    mismatches++;
                end
                if (rsp_ch.taken !== want_rsp.taken)
                begin
                    $display("%0t: taken expected %b actual %b",
                             $time, want_rsp.taken, rsp_ch.taken);
                    mismatches++;
                end
                if (rsp_ch.counter_state !== want_rsp.counter_state)
                begin
                    $display("%0t: counter_state expected %0d actual %0d",
                             $time, want_rsp.counter_state, rsp_ch.counter_state);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int              sel;
        logic [PC_W-1:0] pc;

        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.opcode      = OP_PREDICT;
        req_ch.pc          = '0;
        req_ch.target      = '0;
        req_ch.was_correct = 1'b0;
        rsp_ch.ready       = 1'b0;

        dir_state = CS_WEAK_T;
        for (int k = 0; k < BTB_ENTRIES; k++)
        begin
            btb_valid[k]  = 1'b0;
            btb_tag[k]    = '0;
            btb_target[k] = '0;
        end

        add_req(OP_PREDICT, 32'h0000_0000, 32'h0000_0000, 1'b0);
        add_req(OP_PREDICT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        add_req(OP_INSTALL, 32'hFFFF_FFFC, 32'h1234_5678, 1'b1);
        add_req(OP_PREDICT, 32'hFFFF_FFFC, 32'h0000_0000, 1'b0);
        add_req(OP_INSTALL, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        add_req(OP_PREDICT, 32'h0000_0000, 32'h0000_0000, 1'b0);
        add_req(OP_PREDICT, 32'h0000_0100, 32'h0000_0000, 1'b0);
        add_req(OP_OUTCOME, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        add_req(OP_OUTCOME, 32'h0000_0000, 32'h0000_0000, 1'b1);
        add_req(OP_OUTCOME, 32'h0000_0000, 32'h0000_0000, 1'b0);
        add_req(OP_OUTCOME, 32'h0000_0000, 32'h0000_0000, 1'b0);
        add_req(OP_PREDICT, 32'h0000_0000, 32'h0000_0000, 1'b0);
        add_req(OP_OUTCOME, 32'h0000_0000, 32'h0000_0000, 1'b0);
        add_req(OP_OUTCOME, 32'h0000_0000, 32'h0000_0000, 1'b0);
        add_req(OP_OUTCOME, 32'h0000_0000, 32'h0000_0000, 1'b1);
        add_req(OP_OUTCOME, 32'h0000_0000, 32'h0000_0000, 1'b1);
        add_req(OP_PREDICT, 32'hFFFF_FFFC, 32'h0000_0000, 1'b0);
        add_req(OP_OUTCOME, 32'h0000_0000, 32'h0000_0000, 1'b0);
        add_req(OP_UNUSED,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        add_req(OP_INSTALL, 32'h0000_0000, 32'hAAAA_AAAA, 1'b0);
        add_req(OP_PREDICT, 32'h0000_0000, 32'h5555_5555, 1'b1);
        add_req(OP_INSTALL, 32'h5555_5555, 32'h5555_5555, 1'b1);
        add_req(OP_PREDICT, 32'h5555_5555, 32'h0000_0000, 1'b0);
        add_req(OP_OUTCOME, 32'h0000_0000, 32'h0000_0000, 1'b0);
        add_req(OP_PREDICT, 32'h0000_0000, 32'h0000_0000, 1'b0);

        addr_pool[0] = 32'hFFFF_FFFC;
        for (int k = 1; k < POOL_SIZE; k++)
            addr_pool[k] = $urandom;

        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i % 300 == 299)
                addr_pool[$urandom_range(1, POOL_SIZE - 1)] = $urandom;
            pc  = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            sel = $urandom_range(0, 99);
            if (sel < 38)
                add_req(OP_PREDICT, pc, $urandom, 1'($urandom_range(0, 1)));
            else if (sel < 41)
                add_req(OP_PREDICT, $urandom, $urandom, 1'($urandom_range(0, 1)));
            else if (sel < 62)
                add_req(OP_INSTALL, pc, $urandom, 1'($urandom_range(0, 1)));
            else if (sel < 64)
                add_req(OP_INSTALL, $urandom, $urandom, 1'($urandom_range(0, 1)));
            else if (sel < 92)
                add_req(OP_OUTCOME, pc, $urandom, 1'($urandom_range(0, 1)),
                        (i == 700 || i == 1400));
            else if (sel < 96)
                add_req(OP_UNUSED, pc, $urandom, 1'($urandom_range(0, 1)));
            else
                add_req(2'($urandom_range(0, 3)), $urandom, $urandom,
                        1'($urandom_range(0, 1)));
        end
        add_req(OP_PREDICT, addr_pool[0], $urandom, 1'b0, 1'b1);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending.size() != 0 || req_ch.valid || expected_rsp.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0 && expected_rsp.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
